@@ hdl/dct8_pkg.sv @@
// Shared constants, cosine table and weight lookup for the eight-point integer DCT.
package dct8_pkg;

   localparam int POINTS           = 8;
   localparam int IDX_WIDTH        = $clog2(POINTS);
   localparam int SAMPLE_WIDTH_DEF = 20;
   localparam int WEIGHT_WIDTH     = 14;
   localparam int COEF_WIDTH       = 22;
   localparam int AC_SHIFT         = 13;
   localparam int DC_DIV_WIDTH     = 14;

   localparam logic [DC_DIV_WIDTH-1:0] DC_DIVISOR = 14'h2d41;
   localparam logic signed [WEIGHT_WIDTH-1:0] INV_DC_WEIGHT = 14'sd2896;

   typedef logic signed [WEIGHT_WIDTH-1:0] weight_type;
   typedef logic [IDX_WIDTH-1:0] index_type;

   // Q12 cosine table, row-major: entry {row, col}.
   localparam weight_type FWD_TABLE [POINTS*POINTS] = '{
      14'sd4096, 14'sd4096, 14'sd4096, 14'sd4096,
      14'sd4096, 14'sd4096, 14'sd4096, 14'sd4096,
      14'sd4017, 14'sd3405, 14'sd2275, 14'sd799,
      -14'sd799, -14'sd2275, -14'sd3405, -14'sd4017,
      14'sd3784, 14'sd1567, -14'sd1567, -14'sd3784,
      -14'sd3784, -14'sd1567, 14'sd1567, 14'sd3784,
      14'sd3405, -14'sd799, -14'sd4017, -14'sd2275,
      14'sd2275, 14'sd4017, 14'sd799, -14'sd3405,
      14'sd2896, -14'sd2896, -14'sd2896, 14'sd2896,
      14'sd2896, -14'sd2896, -14'sd2896, 14'sd2896,
      14'sd2275, -14'sd4017, 14'sd799, 14'sd3405,
      -14'sd3405, -14'sd799, 14'sd4017, -14'sd2275,
      14'sd1567, -14'sd3784, 14'sd3784, -14'sd1567,
      -14'sd1567, 14'sd3784, -14'sd3784, 14'sd1567,
      14'sd799, -14'sd2275, 14'sd3405, -14'sd4017,
      14'sd4017, -14'sd3405, 14'sd2275, -14'sd799
   };

   // Inverse mode reads the transposed table with the DC column scaled by 1/sqrt2.
   function automatic weight_type weight_of(input logic inv, input index_type row,
                                            input index_type col);
      weight_type w;
      if (!inv) begin
         w = FWD_TABLE[{row, col}];
      end else if (col == '0) begin
         w = INV_DC_WEIGHT;
      end else begin
         w = FWD_TABLE[{col, row}];
      end
      return w;
   endfunction

endpackage

@@ hdl/dct_8_point_integer.sv @@
// Eight-point integer DCT-II / inverse DCT with one shared multiply-accumulate unit.
// Samples one to seven are each taken on start while idle and busy stays low.
// The eighth sample raises busy; each coefficient is formed on the single MAC from eight
// products, a drain step and a rounding step, and in forward mode coefficient 0, the DC
// quotient, also passes through the divider before it is shown.
// Busy falls as the last coefficient is shown; reset clears the fill count and mode.
module dct_8_point_integer #(
   parameter int SAMPLE_WIDTH = dct8_pkg::SAMPLE_WIDTH_DEF
) (
   input  logic                                     clock,
   input  logic                                     reset,
   input  logic                                     start,
   output logic                                     busy,
   input  logic signed [SAMPLE_WIDTH-1:0]           req_sample,
   output logic                                     rsp_strobe,
   output logic signed [dct8_pkg::COEF_WIDTH-1:0]   rsp_coefficient,
   output logic [dct8_pkg::IDX_WIDTH-1:0]           rsp_out_index,
   output logic                                     rsp_last,
   input  logic                                     csr_we,
   input  logic                                     csr_wdata
);
   import dct8_pkg::*;

   localparam int PROD_WIDTH = SAMPLE_WIDTH + WEIGHT_WIDTH;
   localparam int ACC_WIDTH  = PROD_WIDTH + IDX_WIDTH;
   localparam logic [ACC_WIDTH-1:0] POS_LIMIT = ACC_WIDTH'((2 ** (COEF_WIDTH - 1)) - 1);
   localparam logic [ACC_WIDTH-1:0] NEG_LIMIT = ACC_WIDTH'(2 ** (COEF_WIDTH - 1));
   localparam logic signed [COEF_WIDTH-1:0] COEF_MAX = {1'b0, {(COEF_WIDTH-1){1'b1}}};
   localparam logic signed [COEF_WIDTH-1:0] COEF_MIN = {1'b1, {(COEF_WIDTH-1){1'b0}}};

   localparam logic [2:0] ST_IDLE  = 3'd0;
   localparam logic [2:0] ST_MAC   = 3'd1;
   localparam logic [2:0] ST_DRAIN = 3'd2;
   localparam logic [2:0] ST_ROUND = 3'd3;
   localparam logic [2:0] ST_DIV   = 3'd4;

   logic [2:0]                    state_ff, state_in;
   index_type                     fill_ff, fill_in;
   index_type                     row_ff, row_in;
   index_type                     col_ff, col_in;
   logic                          inverse_ff;
   logic signed [SAMPLE_WIDTH-1:0] sample_ff [POINTS];
   logic signed [PROD_WIDTH-1:0]  prod_ff;
   logic                          prod_vld_ff, prod_vld_in;
   logic signed [ACC_WIDTH-1:0]   acc_ff, acc_in;
   logic                          strobe_ff, strobe_in;
   logic signed [COEF_WIDTH-1:0]  coef_ff, coef_in;
   index_type                     index_ff;
   logic                          last_ff;

   logic                          accept;
   logic                          acc_neg;
   logic [ACC_WIDTH-1:0]          acc_mag;
   logic [ACC_WIDTH-1:0]          quot_mag;
   logic                          div_start;
   logic                          div_done;
   logic [ACC_WIDTH-1:0]          div_quotient;
   logic                          emit;
   logic                          dc_forward;

   assign accept     = start && (state_ff == ST_IDLE);
   assign acc_neg    = acc_ff[ACC_WIDTH-1];
   assign acc_mag    = acc_neg ? ACC_WIDTH'(-acc_ff) : ACC_WIDTH'(acc_ff);
   assign dc_forward = (row_ff == '0) && !inverse_ff;

   dct8_div #(
      .DIVIDEND_WIDTH(ACC_WIDTH)
   ) u_div (
      .clock        (clock),
      .reset        (reset),
      .div_start    (div_start),
      .div_dividend (acc_mag),
      .div_done     (div_done),
      .div_quotient (div_quotient)
   );

   // Truncation toward zero: divide the magnitude, then restore the sign and saturate.
   always_comb begin
      quot_mag = (state_ff == ST_DIV) ? div_quotient : (acc_mag >> AC_SHIFT);
      if (acc_neg) begin
         coef_in = (quot_mag > NEG_LIMIT) ? COEF_MIN : COEF_WIDTH'(-quot_mag);
      end else begin
         coef_in = (quot_mag > POS_LIMIT) ? COEF_MAX : COEF_WIDTH'(quot_mag);
      end
   end

   always_comb begin
      state_in    = state_ff;
      fill_in     = fill_ff;
      row_in      = row_ff;
      col_in      = col_ff;
      acc_in      = acc_ff;
      prod_vld_in = 1'b0;
      div_start   = 1'b0;
      emit        = 1'b0;
      if (prod_vld_ff) begin
         acc_in = acc_ff + ACC_WIDTH'(prod_ff);
      end
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               fill_in = fill_ff + 1'b1;
               if (fill_ff == index_type'(POINTS - 1)) begin
                  state_in = ST_MAC;
                  row_in   = '0;
                  col_in   = '0;
                  acc_in   = '0;
               end
            end
         end
         ST_MAC: begin
            prod_vld_in = 1'b1;
            col_in      = col_ff + 1'b1;
            if (col_ff == index_type'(POINTS - 1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_ROUND;
         end
         ST_ROUND: begin
            if (dc_forward) begin
               div_start = 1'b1;
               state_in  = ST_DIV;
            end else begin
               emit = 1'b1;
            end
         end
         ST_DIV: begin
            emit = div_done;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
      if (emit) begin
         acc_in = '0;
         col_in = '0;
         if (row_ff == index_type'(POINTS - 1)) begin
            state_in = ST_IDLE;
         end else begin
            row_in   = row_ff + 1'b1;
            state_in = ST_MAC;
         end
      end
   end

   assign strobe_in = emit;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         inverse_ff  <= 1'b0;
         prod_vld_ff <= 1'b0;
         strobe_ff   <= 1'b0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         prod_vld_ff <= prod_vld_in;
         strobe_ff   <= strobe_in;
         if (csr_we) begin
            inverse_ff <= csr_wdata;
         end
      end
      if (accept) begin
         sample_ff[fill_ff] <= req_sample;
      end
      prod_ff <= PROD_WIDTH'(sample_ff[col_ff]) * PROD_WIDTH'(weight_of(inverse_ff, row_ff,
                                                                         col_ff));
      row_ff  <= row_in;
      col_ff  <= col_in;
      acc_ff  <= acc_in;
      if (emit) begin
         coef_ff  <= coef_in;
         index_ff <= row_ff;
         last_ff  <= (row_ff == index_type'(POINTS - 1));
      end
   end

   assign busy            = (state_ff != ST_IDLE);
   assign rsp_strobe      = strobe_ff;
   assign rsp_coefficient = coef_ff;
   assign rsp_out_index   = index_ff;
   assign rsp_last        = last_ff;

   a_eighth_sample_busy: assert property (@(posedge clock) disable iff (reset)
      accept && (fill_ff == index_type'(POINTS - 1)) |=> busy)
      else $error("eighth item did not start the transform");
   a_strobe_spacing: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |=> !rsp_strobe)
      else $error("two results in consecutive cycles");
   a_strobe_mid_vector_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_last |-> busy)
      else $error("block idle before the last result");
   a_div_done_state: assert property (@(posedge clock) disable iff (reset)
      div_done |-> state_ff == ST_DIV)
      else $error("divider finished outside the divide step");

endmodule

@@ hdl/dct8_div.sv @@
// Divider of an unsigned magnitude by the forward DC divisor, by reciprocal multiplication.
module dct8_div #(
   parameter int DIVIDEND_WIDTH = dct8_pkg::SAMPLE_WIDTH_DEF + 17
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      div_start,
   input  logic [DIVIDEND_WIDTH-1:0] div_dividend,
   output logic                      div_done,
   output logic [DIVIDEND_WIDTH-1:0] div_quotient
);
   import dct8_pkg::*;

   // Magnitudes of 2**36 and above give a quotient far beyond the coefficient range,
   // so they are clamped to the largest 36-bit value and still saturate downstream.
   localparam int WORK_WIDTH  = 36;
   localparam int TOP_SHIFT   = 12;
   localparam int TOP_WIDTH   = WORK_WIDTH - TOP_SHIFT;
   localparam int RECIP_WIDTH = 23;
   localparam int EST_WIDTH   = TOP_WIDTH + RECIP_WIDTH;
   localparam int QUO_WIDTH   = EST_WIDTH - TOP_WIDTH;
   localparam int REM_WIDTH   = 16;
   localparam int DIV_VALUE   = int'(DC_DIVISOR);

   localparam logic [63:0] WORK_MAX = 64'((longint'(1) << WORK_WIDTH) - 1);
   localparam logic [RECIP_WIDTH-1:0] DC_RECIP =
      RECIP_WIDTH'((longint'(1) << WORK_WIDTH) / longint'(DIV_VALUE));
   localparam logic [REM_WIDTH-1:0] REM_ONE   = REM_WIDTH'(DIV_VALUE);
   localparam logic [REM_WIDTH-1:0] REM_TWO   = REM_WIDTH'(2 * DIV_VALUE);
   localparam logic [REM_WIDTH-1:0] REM_THREE = REM_WIDTH'(3 * DIV_VALUE);

   logic [2:0]            stage_ff, stage_in;
   logic                  done_ff, done_in;
   logic [63:0]           dividend_wide;
   logic [WORK_WIDTH-1:0] x_ff, x_in;
   logic [EST_WIDTH-1:0]  est_ff, est_in;
   logic [QUO_WIDTH-1:0]  qest_ff, qest_in;
   logic [REM_WIDTH-1:0]  rem_ff, rem_in;
   logic [QUO_WIDTH-1:0]  quo_ff, quo_in;

   assign dividend_wide = 64'(div_dividend);

   // The estimate from the top 24 bits of the dividend never exceeds the true quotient and
   // falls short of it by at most two, so the remainder stays below three divisors.
   always_comb begin
      stage_in = {stage_ff[1:0], div_start};
      done_in  = stage_ff[2];
      x_in     = x_ff;
      est_in   = est_ff;
      qest_in  = qest_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      if (div_start) begin
         x_in = (dividend_wide > WORK_MAX) ? '1 : dividend_wide[WORK_WIDTH-1:0];
      end
      if (stage_ff[0]) begin
         est_in = EST_WIDTH'(x_ff[WORK_WIDTH-1:TOP_SHIFT]) * EST_WIDTH'(DC_RECIP);
      end
      if (stage_ff[1]) begin
         qest_in = est_ff[EST_WIDTH-1:TOP_WIDTH];
         rem_in  = REM_WIDTH'(x_ff - WORK_WIDTH'(est_ff[EST_WIDTH-1:TOP_WIDTH])
                                     * WORK_WIDTH'(DC_DIVISOR));
      end
      if (stage_ff[2]) begin
         if (rem_ff >= REM_TWO) begin
            quo_in = qest_ff + QUO_WIDTH'(2);
         end else if (rem_ff >= REM_ONE) begin
            quo_in = qest_ff + QUO_WIDTH'(1);
         end else begin
            quo_in = qest_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         stage_ff <= '0;
         done_ff  <= 1'b0;
      end else begin
         stage_ff <= stage_in;
         done_ff  <= done_in;
      end
      x_ff    <= x_in;
      est_ff  <= est_in;
      qest_ff <= qest_in;
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
   end

   assign div_done     = done_ff;
   assign div_quotient = DIVIDEND_WIDTH'(quo_ff);

   a_no_start_busy: assert property (@(posedge clock) disable iff (reset)
      div_start |-> (stage_ff == '0))
      else $error("divider restarted while busy");
   a_done_after_stage: assert property (@(posedge clock) disable iff (reset)
      done_ff |-> $past(stage_ff[2]))
      else $error("divider done without a finished run");
   a_rem_below_bound: assert property (@(posedge clock) disable iff (reset)
      stage_ff[2] |-> rem_ff < REM_THREE)
      else $error("divider remainder out of range");

endmodule
